// ===== rtl/apst_pkg.sv =====
// Shared types, constants and a helper function for the access point scan table.
`timescale 1ns / 1ps
package apst_pkg;
	localparam int MAX_ENTRIES = 48;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [15:0] DROP_LIMIT = 16'hFFFF;

	localparam logic [2:0] OP_OBSERVE = 3'd0;
	localparam logic [2:0] OP_LOOKUP  = 3'd1;
	localparam logic [2:0] OP_FIND    = 3'd2;
	localparam logic [2:0] OP_SORT    = 3'd3;
	localparam logic [2:0] OP_EXPIRE  = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	localparam logic [2:0] CM_HOLD  = 3'd0;
	localparam logic [2:0] CM_ROT   = 3'd1;
	localparam logic [2:0] CM_MARK  = 3'd2;
	localparam logic [2:0] CM_PASS  = 3'd3;
	localparam logic [2:0] CM_WRITE = 3'd4;

	typedef struct packed {
		logic [47:0]       address;
		logic [255:0]      name;
		logic signed [7:0] strength;
		logic [7:0]        channel;
		logic [2:0]        security;
		logic [31:0]       first_time;
		logic [31:0]       last_time;
		logic              keep;
	} entry_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic             phase;
		logic             by_keep;
		logic [CNT_W-1:0] count;
		logic [31:0]      cutoff;
		logic [IDX_W-1:0] wr_idx;
		logic             wr_keep_first;
		entry_t           wr_data;
	} cell_ctrl_t;

	// SSID equality: bytes compared in order, stopping after the first shared zero byte.
	function automatic logic ssid_equal(input logic [255:0] a, input logic [255:0] b);
		logic eq;
		logic stop;
		eq = 1'b1;
		stop = 1'b0;
		for (int k = 0; k < 32; k++) begin
			if (!stop) begin
				if (a[k*8 +: 8] != b[k*8 +: 8]) begin
					eq = 1'b0;
					stop = 1'b1;
				end else if (a[k*8 +: 8] == 8'd0) begin
					stop = 1'b1;
				end
			end
		end
		return eq;
	endfunction
endpackage

// ===== rtl/apst_cell.sv =====
// One table slot: holds an entry, rotates, marks its keep flag, compare-swaps with neighbors, takes writes.
`timescale 1ns / 1ps
module apst_cell (
	input  logic                      clk,
	input  logic [apst_pkg::IDX_W-1:0] idx,
	input  apst_pkg::cell_ctrl_t      ctrl,
	input  apst_pkg::entry_t          left_e,
	input  apst_pkg::entry_t          right_e,
	output apst_pkg::entry_t          e
);
	apst_pkg::entry_t e_q;
	apst_pkg::entry_t wr_e;
	logic [apst_pkg::CNT_W-1:0] idx_c;
	logic is_left, is_right, swap_r, swap_l;

	assign e = e_q;
	assign idx_c = apst_pkg::CNT_W'(idx);
	assign is_left = (idx[0] == ctrl.phase) && ((idx_c + 1'b1) < ctrl.count);
	assign is_right = (idx[0] != ctrl.phase) && (idx_c != '0) && (idx_c < ctrl.count);
	assign swap_r = ctrl.by_keep ? (!e_q.keep && right_e.keep) : (e_q.strength < right_e.strength);
	assign swap_l = ctrl.by_keep ? (!left_e.keep && e_q.keep) : (left_e.strength < e_q.strength);

	// An update of an existing entry keeps the first sighting time it already holds.
	always_comb begin
		wr_e = ctrl.wr_data;
		if (ctrl.wr_keep_first) wr_e.first_time = e_q.first_time;
	end

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			apst_pkg::CM_ROT: e_q <= right_e;
			apst_pkg::CM_MARK: e_q.keep <= (e_q.last_time >= ctrl.cutoff);
			apst_pkg::CM_PASS: begin
				if (is_left && swap_r) e_q <= right_e;
				else if (is_right && swap_l) e_q <= left_e;
			end
			apst_pkg::CM_WRITE: begin
				if (idx == ctrl.wr_idx) e_q <= wr_e;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/access_point_scan_table.sv =====
// Top level of the access point scan table: a ring of entry cells and its sequencer.
`timescale 1ns / 1ps
// Observe, lookup and find-SSID each rotate the cell ring one full turn past the single
// compare point at cell zero before the result is given.
// Sort and expire run odd-even transposition passes; expire first marks the entries to keep.
// Clear and unused codes give their result in the cycle after acceptance. One item is in work at a time.
// Reset (arst_n low) empties the table and clears the drop counter; entry data is not reset.
module access_point_scan_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [47:0] bssid,
	input  logic [63:0] ssid_w0,
	input  logic [63:0] ssid_w1,
	input  logic [63:0] ssid_w2,
	input  logic [63:0] ssid_w3,
	input  logic signed [7:0] signal_strength,
	input  logic [7:0]  radio_channel,
	input  logic [2:0]  security_kind,
	input  logic [31:0] first_seen_time,
	input  logic [31:0] time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [5:0]  entry_index,
	output logic [5:0]  match_count,
	output logic [5:0]  entries_held,
	output logic [15:0] drops_seen
);
	localparam int N = apst_pkg::MAX_ENTRIES;
	localparam int CW = apst_pkg::CNT_W;
	localparam int IW = apst_pkg::IDX_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_MARK = 3'd2;
	localparam logic [2:0] ST_PASS = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]  state_q;
	logic [2:0]  op_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] count_q;
	logic [15:0] drops_q;
	logic        hit_q;
	logic [IW-1:0] hit_idx_q;
	logic signed [7:0] best_q;
	logic [CW-1:0] matches_q;
	logic [CW-1:0] kept_q;
	logic [N-1:0]  keepv_q;
	apst_pkg::entry_t req_q;
	logic        out_valid_q;
	logic        found_q;
	logic [5:0]  index_q;
	logic [5:0]  mcount_q;

	apst_pkg::entry_t   cells [N];
	apst_pkg::cell_ctrl_t ctrl;
	apst_pkg::entry_t   head;
	logic head_valid, last_step, name_hit, accept, full;

	// The ring: each cell sees its two neighbors; the last cell's right neighbor is cell zero,
	// so a rotation moves every entry one place toward the head.
	for (genvar i = 0; i < N; i++) begin : g_cell
		apst_cell u_cell (
			.clk     (clk),
			.idx     (IW'(i)),
			.ctrl    (ctrl),
			.left_e  (cells[(i + N - 1) % N]),
			.right_e (cells[(i + 1) % N]),
			.e       (cells[i])
		);
	end

	assign head = cells[0];
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign head_valid = step_q < count_q;
	assign last_step = step_q == CW'(N - 1);
	assign full = count_q >= CW'(N);
	// An empty query matches nothing.
	assign name_hit = (req_q.name[7:0] != 8'd0) && apst_pkg::ssid_equal(head.name, req_q.name);

	always_comb begin
		ctrl = '0;
		ctrl.count = count_q;
		ctrl.cutoff = req_q.last_time;
		ctrl.phase = step_q[0];
		ctrl.by_keep = (op_q == apst_pkg::OP_EXPIRE);
		ctrl.wr_data = req_q;
		ctrl.wr_idx = hit_q ? hit_idx_q : IW'(count_q);
		ctrl.wr_keep_first = hit_q;
		if (!hit_q && req_q.first_time == 32'd0) ctrl.wr_data.first_time = req_q.last_time;
		case (state_q)
			ST_SCAN: ctrl.mode = apst_pkg::CM_ROT;
			ST_MARK: ctrl.mode = apst_pkg::CM_MARK;
			ST_PASS: ctrl.mode = apst_pkg::CM_PASS;
			ST_FIN: begin
				if (op_q == apst_pkg::OP_OBSERVE && (hit_q || !full)) ctrl.mode = apst_pkg::CM_WRITE;
				else ctrl.mode = apst_pkg::CM_HOLD;
			end
			default: ctrl.mode = apst_pkg::CM_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drops_q <= '0;
			out_valid_q <= 1'b0;
			op_q <= '0;
			step_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= operation;
						step_q <= '0;
						hit_q <= 1'b0;
						matches_q <= '0;
						kept_q <= '0;
						req_q.address <= bssid;
						req_q.name <= {ssid_w3, ssid_w2, ssid_w1, ssid_w0};
						req_q.strength <= signal_strength;
						req_q.channel <= radio_channel;
						req_q.security <= security_kind;
						req_q.first_time <= first_seen_time;
						req_q.last_time <= time_ms;
						req_q.keep <= 1'b0;
						if (operation == apst_pkg::OP_OBSERVE || operation == apst_pkg::OP_LOOKUP ||
						    operation == apst_pkg::OP_FIND) begin
							state_q <= ST_SCAN;
						end else if (operation == apst_pkg::OP_SORT) begin
							state_q <= ST_PASS;
						end else if (operation == apst_pkg::OP_EXPIRE) begin
							state_q <= ST_MARK;
						end else begin
							// Clear and unused codes finish at once.
							if (operation == apst_pkg::OP_CLEAR) count_q <= '0;
							out_valid_q <= 1'b1;
							found_q <= 1'b0;
							index_q <= '0;
							mcount_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (head_valid) begin
						if (op_q == apst_pkg::OP_FIND) begin
							if (name_hit) begin
								matches_q <= matches_q + 1'b1;
								if (!hit_q || head.strength > best_q) begin
									hit_q <= 1'b1;
									hit_idx_q <= IW'(step_q);
									best_q <= head.strength;
								end
							end
						end else if (!hit_q && head.address == req_q.address) begin
							hit_q <= 1'b1;
							hit_idx_q <= IW'(step_q);
						end
					end
					if (last_step) state_q <= ST_FIN;
				end
				ST_MARK: begin
					for (int i = 0; i < N; i++) begin
						keepv_q[i] <= (CW'(i) < count_q) && (cells[i].last_time >= req_q.last_time);
					end
					state_q <= ST_PASS;
				end
				ST_PASS: begin
					step_q <= step_q + 1'b1;
					// Kept entries are tallied from a private copy of the keep flags.
					keepv_q <= keepv_q >> 1;
					if (keepv_q[0]) kept_q <= kept_q + 1'b1;
					if (last_step) state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
					found_q <= 1'b0;
					index_q <= '0;
					mcount_q <= '0;
					case (op_q)
						apst_pkg::OP_OBSERVE: begin
							if (hit_q) begin
								found_q <= 1'b1;
								index_q <= 6'(hit_idx_q);
							end else if (full) begin
								if (drops_q != apst_pkg::DROP_LIMIT) drops_q <= drops_q + 1'b1;
							end else begin
								found_q <= 1'b1;
								index_q <= 6'(count_q);
								count_q <= count_q + 1'b1;
							end
						end
						apst_pkg::OP_LOOKUP: begin
							found_q <= hit_q;
							index_q <= hit_q ? 6'(hit_idx_q) : 6'd0;
						end
						apst_pkg::OP_FIND: begin
							found_q <= hit_q;
							index_q <= hit_q ? 6'(hit_idx_q) : 6'd0;
							mcount_q <= 6'(matches_q);
						end
						apst_pkg::OP_EXPIRE: count_q <= kept_q;
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign entry_index = index_q;
	assign match_count = mcount_q;
	assign entries_held = 6'(count_q);
	assign drops_seen = drops_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(N))
		else $error("entry count above table size");
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result pending while an item is in work");
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q) |-> (CW'(index_q) < count_q))
		else $error("reported index outside the held entries");
	a_drops_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		drops_q >= $past(drops_q))
		else $error("drop counter went down");
endmodule
